FILE: rtl/bsc_pkg.sv
`default_nettype none
package bsc_pkg;

  // fixed shape of the process tables and the pool
  localparam int NRES        = 3;
  localparam int RES_W       = 8;
  localparam int POOL_W      = 13;
  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = 4;
  localparam int CNT_W       = 5;
  localparam int CFG_ADDR_W  = 2;

  localparam logic [POOL_W-1:0] POOL_MAX = {POOL_W{1'b1}};

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_FREE_A = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_FREE_B = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_FREE_C = 2'd2;

  typedef logic [RES_W-1:0]  res_t;
  typedef logic [POOL_W-1:0] pool_t;
  typedef res_t  [NRES-1:0]  res3_t;
  typedef pool_t [NRES-1:0]  pool3_t;

  // result of one check of a table entry against the pool
  typedef struct packed {
    logic   fits;
    pool3_t sum;
  } alu_res_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_OUT  = 3'b100
  } state_t;

endpackage
`default_nettype wire

FILE: rtl/bsc_alu.sv
`default_nettype none
module bsc_alu (
  input  var bsc_pkg::res3_t    need,
  input  var bsc_pkg::res3_t    held,
  input  var bsc_pkg::pool3_t   pool,
  output var bsc_pkg::alu_res_t res
);
  import bsc_pkg::*;

  // need-fits compare and saturating pool add, per resource
  always_comb begin
    logic [POOL_W:0] s;
    res.fits = 1'b1;
    for (int r = 0; r < NRES; r++) begin
      if ({{(POOL_W-RES_W){1'b0}}, need[r]} > pool[r]) begin
        res.fits = 1'b0;
      end
      s = {1'b0, pool[r]} + {{(POOL_W-RES_W+1){1'b0}}, held[r]};
      res.sum[r] = s[POOL_W] ? POOL_MAX : s[POOL_W-1:0];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/bankers_safety_check_top.sv
`default_nettype none
// Loading: one process record per cycle while s_tready is high.
// Search: each pass scans the stored entries one per cycle through the shared
// check unit and stops at the first entry that fits or after the last entry.
// The block takes no record after the final one until the last result is taken.
// rst (synchronous) clears the free registers, pool, record count and done mask.
module bankers_safety_check_top #(
  parameter int MAX_PROCESSES = 16
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              cfg_we,
  input  wire [bsc_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  wire [bsc_pkg::RES_W-1:0]         cfg_wdata,
  input  wire                              s_tvalid,
  output logic                             s_tready,
  // max_a, max_b, max_c, held_a, held_b, held_c
  input  wire [47:0]                       s_tdata,
  input  wire                              s_tlast,
  output logic                             m_tvalid,
  input  wire                              m_tready,
  // process_index, zero fill
  output logic [7:0]                       m_tdata,
  // safe
  output logic [0:0]                       m_tuser,
  output logic                             m_tlast
);
  import bsc_pkg::*;

  localparam int CAP = (MAX_PROCESSES > TABLE_DEPTH) ? TABLE_DEPTH : MAX_PROCESSES;

  state_t             state;
  res3_t              free_regs;
  res3_t              need_tbl [TABLE_DEPTH];
  res3_t              held_tbl [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] done_mask;
  pool3_t             pool;
  logic [CNT_W-1:0]   process_count;
  logic [CNT_W-1:0]   finished;
  logic [IDX_W-1:0]   ptr;
  logic [IDX_W-1:0]   out_idx;
  logic               out_safe;
  logic               out_last;

  res3_t              rec_need;
  res3_t              rec_held;
  alu_res_t           alu;
  logic               in_acc;
  logic               store;
  logic               cand;
  logic               ptr_last;
  logic [CNT_W-1:0]   finished_next;

  // unpack record and work out the need
  always_comb begin
    res_t mx;
    res_t hd;
    for (int r = 0; r < NRES; r++) begin
      mx = s_tdata[RES_W*r +: RES_W];
      hd = s_tdata[RES_W*(NRES+r) +: RES_W];
      rec_held[r] = hd;
      rec_need[r] = (mx > hd) ? res_t'(mx - hd) : '0;
    end
  end

  bsc_alu u_alu (
    .need (need_tbl[ptr]),
    .held (held_tbl[ptr]),
    .pool (pool),
    .res  (alu)
  );

  assign s_tready      = (state == S_IDLE);
  assign in_acc        = s_tvalid && s_tready;
  assign store         = in_acc && (process_count < CNT_W'(CAP));
  assign cand          = !done_mask[ptr] && alu.fits;
  assign ptr_last      = ({1'b0, ptr} == (process_count - CNT_W'(1)));
  assign finished_next = finished + CNT_W'(1);

  // record tables
  always_ff @(posedge clk) begin
    if (store) begin
      need_tbl[process_count[IDX_W-1:0]] <= rec_need;
      held_tbl[process_count[IDX_W-1:0]] <= rec_held;
    end
  end

  // free registers
  always_ff @(posedge clk) begin
    if (rst) begin
      free_regs <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_FREE_A: free_regs[0] <= cfg_wdata;
        CFG_FREE_B: free_regs[1] <= cfg_wdata;
        CFG_FREE_C: free_regs[2] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // sequencer: load, scan passes, result hand-off
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      done_mask     <= '0;
      pool          <= '0;
      process_count <= '0;
      finished      <= '0;
      ptr           <= '0;
      out_idx       <= '0;
      out_safe      <= 1'b0;
      out_last      <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (store) begin
              process_count <= process_count + CNT_W'(1);
            end
            if (s_tlast) begin
              for (int r = 0; r < NRES; r++) begin
                pool[r] <= {{(POOL_W-RES_W){1'b0}}, free_regs[r]};
              end
              done_mask <= '0;
              finished  <= '0;
              ptr       <= '0;
              state     <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (cand) begin
            pool           <= alu.sum;
            done_mask[ptr] <= 1'b1;
            finished       <= finished_next;
            out_idx        <= ptr;
            out_safe       <= 1'b1;
            out_last       <= (finished_next == process_count);
            state          <= S_OUT;
          end else if (ptr_last) begin
            out_idx  <= '0;
            out_safe <= 1'b0;
            out_last <= 1'b1;
            state    <= S_OUT;
          end else begin
            ptr <= ptr + IDX_W'(1);
          end
        end
        S_OUT: begin
          if (m_tready) begin
            if (out_last) begin
              process_count <= '0;
              done_mask     <= '0;
              state         <= S_IDLE;
            end else begin
              ptr   <= '0;
              state <= S_SCAN;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_tvalid = (state == S_OUT);
  assign m_tdata  = {{(8-IDX_W){1'b0}}, out_idx};
  assign m_tuser  = out_safe;
  assign m_tlast  = out_last;

  // checks
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input taken while a result is pending");

  a_unsafe_is_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0]) |-> m_tlast)
    else $error("unsafe result not marked last");

  a_run_clears: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast) |=> (process_count == '0 && done_mask == '0))
    else $error("run state not cleared after final result");

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    process_count <= CNT_W'(CAP))
    else $error("record count beyond capacity");

endmodule
`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 1ps
module tb;
  import bsc_pkg::*;

  localparam int CAPACITY     = 16;
  localparam int SETTLE       = 20;
  localparam int HOLD_CYCLES  = 500;
  localparam int QUIET_LIMIT  = 4000;
  localparam int PHASE_ITEMS  = 21;
  localparam int PHASES       = 8;
  localparam logic [CFG_ADDR_W-1:0] CFG_SPARE = 2'd3;

  // one step of the safe sequence as the block reports it
  typedef struct {
    logic [IDX_W-1:0] idx;
    logic             safe;
    logic             last;
  } order_t;

  typedef struct {
    res3_t mx;
    res3_t hd;
  } record_t;

  // holds the process tables and predicts the safe sequence of each run
  class safety_scoreboard;
    res_t             free_units [NRES];
    res3_t            need_tab   [TABLE_DEPTH];
    res3_t            held_tab   [TABLE_DEPTH];
    int unsigned      loaded;
    order_t           order_q [$];
    int               errors;

    function new();
      for (int r = 0; r < NRES; r++) free_units[r] = '0;
      loaded = 0;
      errors = 0;
    endfunction

    function void set_free(logic [CFG_ADDR_W-1:0] idx, res_t v);
      if (idx <= CFG_FREE_C) free_units[idx] = v;
    endfunction

    function int pending();
      return order_q.size();
    endfunction

    // store the record, and on the final one run the whole search
    function void note_record(res3_t mx, res3_t hd, logic final_rec);
      pool3_t                 pool;
      logic [TABLE_DEPTH-1:0] done;
      int unsigned            finished, sum;
      int                     pick;
      bit                     found;
      order_t                 o;
      if (loaded < CAPACITY) begin
        for (int r = 0; r < NRES; r++) begin
          need_tab[loaded][r] = (mx[r] > hd[r]) ? mx[r] - hd[r] : '0;
          held_tab[loaded][r] = hd[r];
        end
        loaded++;
      end
      if (!final_rec) return;
      for (int r = 0; r < NRES; r++) pool[r] = pool_t'(free_units[r]);
      done = '0;
      finished = 0;
      while (finished < loaded) begin
        found = 0;
        pick = 0;
        for (int q = 0; q < loaded; q++) begin
          if (!found && !done[q] && need_tab[q][0] <= pool[0] &&
              need_tab[q][1] <= pool[1] && need_tab[q][2] <= pool[2]) begin
            found = 1;
            pick = q;
          end
        end
        if (!found) begin
          o.idx = '0; o.safe = 1'b0; o.last = 1'b1;
          order_q.push_back(o);
          break;
        end
        // pool saturates rather than wrapping
        for (int r = 0; r < NRES; r++) begin
          sum = pool[r] + held_tab[pick][r];
          pool[r] = (sum > POOL_MAX) ? POOL_MAX : pool_t'(sum);
        end
        done[pick] = 1'b1;
        finished++;
        o.idx = pick[IDX_W-1:0]; o.safe = 1'b1; o.last = (finished == loaded);
        order_q.push_back(o);
      end
      loaded = 0;
    endfunction

    function void check_result(logic [IDX_W-1:0] idx, logic safe, logic last);
      order_t o;
      if (order_q.size() == 0) begin
        $display("%0t: unexpected result: idx %0d safe %0b last %0b",
                 $time, idx, safe, last);
        errors++;
        return;
      end
      o = order_q.pop_front();
      if (idx !== o.idx || safe !== o.safe || last !== o.last) begin
        $display("%0t: result mismatch: expected idx %0d safe %0b last %0b,",
                 $time, o.idx, o.safe, o.last);
        $display("%0t:   got idx %0d safe %0b last %0b", $time, idx, safe, last);
        errors++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [RES_W-1:0]      cfg_wdata;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [47:0]           s_tdata;
  logic                  s_tlast;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [7:0]            m_tdata;
  logic [0:0]            m_tuser;
  logic                  m_tlast;

  bit                    sender_idle;
  bit                    receiver_stall;
  bit                    hold_req;
  int                    idle_pct;
  int                    hold_count;
  int                    quiet;
  safety_scoreboard      sb;

  bankers_safety_check_top dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // receiver: optional long hold-off first, then random stalls or always ready
  initial begin
    m_tready = 1'b0;
    hold_count = 0;
    forever begin
      @(negedge clk);
      if (hold_req && hold_count < HOLD_CYCLES) begin
        m_tready <= 1'b0;
        hold_count++;
      end else if (receiver_stall) begin
        m_tready <= ($urandom_range(99) >= idle_pct);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // handshake monitor
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_record(s_tdata[23:0], s_tdata[47:24], s_tlast);
      if (m_tvalid && m_tready) sb.check_result(m_tdata[IDX_W-1:0], m_tuser[0], m_tlast);
    end
  end

  // watchdog on cycles with no traffic at all
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) quiet = 0;
    else quiet++;
    if (quiet >= QUIET_LIMIT) begin
      $display("%0t: no traffic for %0d cycles", $time, QUIET_LIMIT);
      $display("tb NOT OK");
      $finish;
    end
  end

  // one process record, held until taken; valid stays high afterwards
  task automatic send_record(input record_t rec, input logic final_rec);
    while (sender_idle && $urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {rec.hd, rec.mx};
    s_tlast  <= final_rec;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // stop offering items and wait until the block has delivered everything
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // all three free registers, then a write to the unused index
  task automatic write_free(input res3_t v);
    logic [RES_W-1:0] junk;
    junk = RES_W'($urandom_range(255));
    cfg_we <= 1'b1;
    cfg_addr <= CFG_FREE_A; cfg_wdata <= v[0];
    @(negedge clk);
    cfg_addr <= CFG_FREE_B; cfg_wdata <= v[1];
    @(negedge clk);
    cfg_addr <= CFG_FREE_C; cfg_wdata <= v[2];
    @(negedge clk);
    cfg_addr <= CFG_SPARE; cfg_wdata <= junk;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_free(CFG_FREE_A, v[0]);
    sb.set_free(CFG_FREE_B, v[1]);
    sb.set_free(CFG_FREE_C, v[2]);
    sb.set_free(CFG_SPARE, junk);
  endtask

  // mostly small needs so searches get deep; some fully random and held above max
  function automatic record_t make_record(res3_t cap);
    record_t     rec;
    int unsigned pick, n;
    pick = $urandom_range(9);
    for (int r = 0; r < NRES; r++) begin
      if (pick < 2) begin
        rec.mx[r] = res_t'($urandom_range(255));
        rec.hd[r] = res_t'($urandom_range(255));
      end else if (pick == 2) begin
        rec.hd[r] = res_t'($urandom_range(255, 1));
        rec.mx[r] = res_t'($urandom_range(rec.hd[r] - 1));
      end else begin
        n = $urandom_range(cap[r] / 4 + 2);
        rec.hd[r] = res_t'($urandom_range(255 - n));
        rec.mx[r] = res_t'(rec.hd[r] + n);
      end
    end
    return rec;
  endfunction

  function automatic record_t rec_of(int mx_a, int mx_b, int mx_c,
                                     int hd_a, int hd_b, int hd_c);
    record_t rec;
    rec.mx = {res_t'(mx_c), res_t'(mx_b), res_t'(mx_a)};
    rec.hd = {res_t'(hd_c), res_t'(hd_b), res_t'(hd_a)};
    return rec;
  endfunction

  initial begin
    res3_t  cfg;
    int     sent, len, roll;
    rst = 1'b1;
    cfg_we = 1'b0; cfg_addr = '0; cfg_wdata = '0;
    s_tvalid = 1'b0; s_tdata = '0; s_tlast = 1'b0;
    sender_idle = 0; receiver_stall = 0; hold_req = 0;
    idle_pct = 72;
    quiet = 0;
    sb = new();
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: free registers still at reset, zero need fits, any need does not
    send_record(rec_of(0, 0, 0, 0, 0, 0), 1'b1);
    send_record(rec_of(1, 0, 0, 0, 0, 0), 1'b1);
    wait_drained();

    // full pool: largest need, held above max, all-ones holding
    write_free({res_t'(255), res_t'(255), res_t'(255)});
    send_record(rec_of(255, 255, 255, 0, 0, 0), 1'b0);
    send_record(rec_of(0, 0, 0, 255, 255, 255), 1'b0);
    send_record(rec_of(128, 127, 255, 127, 128, 255), 1'b1);
    wait_drained();

    // search stalls after one entry; later process fits before earlier one
    write_free({res_t'(10), res_t'(10), res_t'(10)});
    send_record(rec_of(20, 5, 5, 5, 0, 0), 1'b0);
    send_record(rec_of(10, 10, 10, 0, 0, 0), 1'b0);
    send_record(rec_of(30, 0, 0, 0, 0, 0), 1'b1);
    // entry 1 fits first but releases none of resource a, which entry 0 needs
    send_record(rec_of(20, 0, 0, 0, 0, 0), 1'b0);
    send_record(rec_of(10, 1, 1, 0, 50, 50), 1'b1);
    wait_drained();

    // random phases over free settings and idling patterns
    for (int k = 0; k < PHASES; k++) begin
      case (k)
        0:       cfg = {res_t'(255), res_t'(255), res_t'(255)};
        1:       cfg = '0;
        3:       cfg = {res_t'($urandom_range(15)), res_t'($urandom_range(15)),
                        res_t'($urandom_range(15))};
        5:       cfg = {res_t'(255), res_t'(0), res_t'(255)};
        7:       cfg = {res_t'(0), res_t'(255), res_t'(0)};
        default: cfg = {res_t'($urandom_range(255)), res_t'($urandom_range(255)),
                        res_t'($urandom_range(255))};
      endcase
      write_free(cfg);
      sender_idle    = (k % 4 == 1) || (k % 4 == 3);
      receiver_stall = (k % 4 == 2) || (k % 4 == 3);
      // light idling on both sides together, heavy idling on one side alone
      idle_pct       = (k % 4 == 3) ? 10 : 72;
      // long receiver hold-off while records keep coming
      if (k == 2) hold_req = 1;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        roll = $urandom_range(99);
        if (roll < 85)      len = $urandom_range(6, 1);
        else if (roll < 95) len = $urandom_range(16, 7);
        else                len = $urandom_range(20, 17);
        for (int i = 0; i < len; i++) send_record(make_record(cfg), i == len - 1);
        sent += len;
      end
      wait_drained();
    end

    repeat (50) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/bsc_pkg.sv
rtl/bsc_alu.sv
rtl/bankers_safety_check_top.sv
tb/tb.sv
